### rtl/thac_pkg.sv
package thac_pkg;

  // Controller modes, as they appear in the result
  localparam logic [2:0] MODE_WAITING   = 3'd0;
  localparam logic [2:0] MODE_SETTING   = 3'd1;
  localparam logic [2:0] MODE_ALARM     = 3'd2;
  localparam logic [2:0] MODE_PRE_ALARM = 3'd3;
  localparam logic [2:0] MODE_PRE_SET   = 3'd4;
  localparam logic [2:0] MODE_ACK_ALARM = 3'd5;

  // Display symbols
  localparam logic [1:0] SYM_CELSIUS = 2'd0;
  localparam logic [1:0] SYM_SETTING = 2'd1;
  localparam logic [1:0] SYM_ALARM   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_INITIAL_SETPOINT = 1'b0;
  localparam logic CFG_IDLE_LIMIT       = 1'b1;

  localparam logic [7:0]  INITIAL_SETPOINT_RST = 8'd30;
  localparam logic [15:0] IDLE_LIMIT_RST       = 16'd10000;
  localparam logic [15:0] IDLE_COUNT_MAX       = 16'hFFFF;

  // Controller state carried from one pass to the next
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  setpoint;
    logic [15:0] idle_count;
    logic        display_lit;
    logic        buzzer_level;
    logic        pending_set;
    logic        pending_up;
    logic        pending_down;
  } ctrl_state_t;

  // One input request
  typedef struct packed {
    logic       tick;
    logic       key_down;
    logic       key_up;
    logic       key_set;
    logic [7:0] temperature;
  } pass_in_t;

  // One result
  typedef struct packed {
    logic [7:0] setpoint_value;
    logic       save_strobe;
    logic       buzzer_active;
    logic       display_on;
    logic [1:0] display_symbol;
    logic [7:0] display_value;
    logic       display_update;
    logic [2:0] mode;
  } pass_out_t;

endpackage

### rtl/thac_step.sv
module thac_step
  import thac_pkg::*;
(
  input  ctrl_state_t state,
  input  pass_in_t    pass_in,
  input  logic [15:0] idle_limit,
  output ctrl_state_t state_next,
  output pass_out_t   result
);

  logic [15:0] idle_ticked;
  logic        timed_out;
  logic        p_set;
  logic        p_up;
  logic        p_down;

  // Latch new keys and count the tick
  always_comb begin
    p_set       = state.pending_set | pass_in.key_set;
    p_up        = state.pending_up | pass_in.key_up;
    p_down      = state.pending_down | pass_in.key_down;
    idle_ticked = (pass_in.tick && state.idle_count != IDLE_COUNT_MAX) ?
                  state.idle_count + 16'd1 : state.idle_count;
    timed_out   = idle_ticked >= idle_limit;
  end

  // One step of the mode sequencer
  always_comb begin
    state_next              = state;
    state_next.pending_set  = p_set;
    state_next.pending_up   = p_up;
    state_next.pending_down = p_down;
    state_next.idle_count   = idle_ticked;
    result                  = '0;

    unique case (state.mode)
      MODE_PRE_SET: begin
        if (timed_out) state_next.mode = MODE_WAITING;
        if (p_set) begin
          state_next.pending_set = 1'b0;
          state_next.mode        = MODE_SETTING;
        end
      end
      MODE_SETTING: begin
        result.display_update   = 1'b1;
        result.display_value    = state.setpoint;
        result.display_symbol   = SYM_SETTING;
        // up and down together cancel out
        state_next.setpoint     = state.setpoint + {7'd0, p_up} - {7'd0, p_down};
        state_next.pending_up   = 1'b0;
        state_next.pending_down = 1'b0;
        if (p_set) begin
          result.save_strobe     = 1'b1;
          state_next.idle_count  = '0;
          state_next.mode        = MODE_WAITING;
          state_next.pending_set = 1'b0;
        end
      end
      MODE_PRE_ALARM: begin
        state_next.display_lit = 1'b1;
        state_next.mode        = MODE_ALARM;
      end
      MODE_ALARM: begin
        state_next.buzzer_level = 1'b1;
        result.display_update   = 1'b1;
        result.display_value    = pass_in.temperature;
        result.display_symbol   = SYM_ALARM;
        if (p_set) begin
          state_next.mode        = MODE_ACK_ALARM;
          state_next.pending_set = 1'b0;
        end
      end
      MODE_ACK_ALARM: begin
        state_next.buzzer_level = 1'b0;
        result.display_update   = 1'b1;
        result.display_value    = pass_in.temperature;
        result.display_symbol   = SYM_ALARM;
        if (pass_in.temperature < state.setpoint) begin
          state_next.mode       = MODE_WAITING;
          state_next.idle_count = '0;
        end
        if (p_set) begin
          state_next.mode        = MODE_SETTING;
          state_next.pending_set = 1'b0;
          state_next.display_lit = 1'b1;
        end
      end
      default: begin
        // waiting, and any code that means nothing
        state_next.mode = MODE_WAITING;
        if (timed_out) begin
          state_next.display_lit = 1'b0;
          state_next.idle_count  = '0;
        end
        if (p_set) begin
          state_next.display_lit = 1'b1;
          state_next.idle_count  = '0;
          state_next.pending_set = 1'b0;
          state_next.mode        = MODE_PRE_SET;
        end
        result.display_update = 1'b1;
        result.display_value  = pass_in.temperature;
        result.display_symbol = SYM_CELSIUS;
        if (pass_in.temperature > state.setpoint) state_next.mode = MODE_PRE_ALARM;
      end
    endcase

    result.mode           = state_next.mode;
    result.display_on     = state_next.display_lit;
    result.buzzer_active  = state_next.buzzer_level;
    result.setpoint_value = state_next.setpoint;
  end

endmodule

### rtl/thermostat_alarm_controller_core.sv
// Thermostat alarm controller: each request on the input stream is one controller pass
// (temperature, newly pressed set/up/down keys, millisecond tick) and yields exactly one
// result on the output stream. A request is captured in an input register, the sequencer
// step runs between that register and the result register, and the controller state is
// updated in the same cycle, so one request per clock is sustained while results are taken.
// The input register frees as soon as its request moves to the result register, so one
// further request is taken while a result waits; after that the input stalls until the
// result is taken.
// Configuration registers must only be written while no request is in flight; writing
// the initial set point also loads the working set point at once.
module thermostat_alarm_controller_core
  import thac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // temperature[7:0], key_set[8], key_up[9], key_down[10], tick[11], zero[15:12]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode[2:0], display_update[3], display_value[11:4], display_symbol[13:12],
  // display_on[14], buzzer_active[15], save_strobe[16], setpoint_value[24:17], zero[31:25]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        in_valid;
  pass_in_t    in_item;
  logic        out_valid;
  pass_out_t   out_item;
  logic        advance;
  logic [15:0] idle_limit;
  ctrl_state_t state;
  ctrl_state_t state_next;
  pass_out_t   result;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_item};

  thac_step u_step (
    .state      (state),
    .pass_in    (in_item),
    .idle_limit (idle_limit),
    .state_next (state_next),
    .result     (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_axis_tdata[11:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // Idle limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RST;
    end else if (cfg_we && cfg_index == CFG_IDLE_LIMIT) begin
      idle_limit <= cfg_data;
    end
  end

  // Controller state: advance one pass per request, reload set point on config
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= MODE_WAITING;
      state.setpoint     <= INITIAL_SETPOINT_RST;
      state.idle_count   <= '0;
      state.display_lit  <= 1'b1;
      state.buzzer_level <= 1'b0;
      state.pending_set  <= 1'b0;
      state.pending_up   <= 1'b0;
      state.pending_down <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_INITIAL_SETPOINT) begin
      state.setpoint <= cfg_data[7:0];
    end else if (advance) begin
      state <= state_next;
    end
  end

  // A save only happens on the way back to waiting
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.save_strobe) |-> (out_item.mode == MODE_WAITING))
    else $error("save strobe outside waiting");

  // The buzzer only sounds in alarm or its acknowledgement
  assert property (@(posedge clk) disable iff (rst)
    state.buzzer_level |-> (state.mode == MODE_ALARM || state.mode == MODE_ACK_ALARM))
    else $error("buzzer on outside alarm modes");

  // A processed request always shows up as a result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed request lost");

  // Without a refresh the display fields stay clear
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.display_update) |->
      (out_item.display_value == 8'd0 && out_item.display_symbol == SYM_CELSIUS))
    else $error("display fields set without refresh");

endmodule

### tb/sv/thac_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port of the thermostat controller,
// runs its own copy of the controller for every accepted request and
// compares each result against the oldest prediction.
module thac_checker
  import thac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned awaiting
);

  // Predicted controller state and its timeout setting
  logic [15:0] blank_after;
  logic [2:0]  mode_q;
  logic [7:0]  setpoint_q;
  logic [15:0] idle_ticks;
  logic        lit_q;
  logic        buzz_q;
  logic        held_set;
  logic        held_up;
  logic        held_down;

  pass_out_t   predicted_results[$];
  int unsigned result_no;

  // Run one controller pass on the predicted state
  function automatic pass_out_t step_controller(input pass_in_t p);
    pass_out_t r;
    logic      timeout_hit;
    r = '0;
    if (p.key_set) held_set = 1'b1;
    if (p.key_up) held_up = 1'b1;
    if (p.key_down) held_down = 1'b1;
    if (p.tick && idle_ticks != IDLE_COUNT_MAX) idle_ticks = idle_ticks + 16'd1;
    timeout_hit = (idle_ticks >= blank_after);

    case (mode_q)
      MODE_PRE_SET: begin
        // expiry does not restart the idle timer
        if (timeout_hit) mode_q = MODE_WAITING;
        if (held_set) begin
          held_set = 1'b0;
          mode_q   = MODE_SETTING;
        end
      end
      MODE_SETTING: begin
        // show the set point as it stood before this pass's keys
        r.display_update = 1'b1;
        r.display_value  = setpoint_q;
        r.display_symbol = SYM_SETTING;
        if (held_up) begin
          setpoint_q = setpoint_q + 8'd1;
          held_up    = 1'b0;
        end
        if (held_down) begin
          setpoint_q = setpoint_q - 8'd1;
          held_down  = 1'b0;
        end
        if (held_set) begin
          r.save_strobe = 1'b1;
          idle_ticks    = '0;
          mode_q        = MODE_WAITING;
          held_set      = 1'b0;
        end
      end
      MODE_PRE_ALARM: begin
        lit_q  = 1'b1;
        mode_q = MODE_ALARM;
      end
      MODE_ALARM: begin
        buzz_q           = 1'b1;
        r.display_update = 1'b1;
        r.display_value  = p.temperature;
        r.display_symbol = SYM_ALARM;
        if (held_set) begin
          mode_q   = MODE_ACK_ALARM;
          held_set = 1'b0;
        end
      end
      MODE_ACK_ALARM: begin
        buzz_q           = 1'b0;
        r.display_update = 1'b1;
        r.display_value  = p.temperature;
        r.display_symbol = SYM_ALARM;
        if (p.temperature < setpoint_q) begin
          mode_q     = MODE_WAITING;
          idle_ticks = '0;
        end
        // a set press overrides the return to waiting
        if (held_set) begin
          mode_q   = MODE_SETTING;
          held_set = 1'b0;
          lit_q    = 1'b1;
        end
      end
      default: begin
        mode_q = MODE_WAITING;
        if (timeout_hit) begin
          lit_q      = 1'b0;
          idle_ticks = '0;
        end
        if (held_set) begin
          lit_q      = 1'b1;
          idle_ticks = '0;
          held_set   = 1'b0;
          mode_q     = MODE_PRE_SET;
        end
        r.display_update = 1'b1;
        r.display_value  = p.temperature;
        r.display_symbol = SYM_CELSIUS;
        // over temperature wins even when set was pressed
        if (p.temperature > setpoint_q) mode_q = MODE_PRE_ALARM;
      end
    endcase

    r.mode           = mode_q;
    r.display_on     = lit_q;
    r.buzzer_active  = buzz_q;
    r.setpoint_value = setpoint_q;
    return r;
  endfunction

  // Count a wrong field, report only the first few
  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $realtime, result_no, fname, want, got);
    end
  endtask

  // Retire results first, then take register writes and new requests
  always @(posedge clk) begin : watch
    pass_out_t got;
    pass_out_t want;
    if (rst) begin
      blank_after = IDLE_LIMIT_RST;
      mode_q      = MODE_WAITING;
      setpoint_q  = INITIAL_SETPOINT_RST;
      idle_ticks  = '0;
      lit_q       = 1'b1;
      buzz_q      = 1'b0;
      held_set    = 1'b0;
      held_up     = 1'b0;
      held_down   = 1'b0;
      mismatches  = 0;
      result_no   = 0;
      predicted_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got       = m_tdata[24:0];
        result_no = result_no + 1;
        if (predicted_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("[%0t] result %0d arrived with nothing outstanding (data %h)",
                     $realtime, result_no, m_tdata);
        end else begin
          want = predicted_results.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("display_update", want.display_update, got.display_update);
          check_field("display_value", want.display_value, got.display_value);
          check_field("display_symbol", want.display_symbol, got.display_symbol);
          check_field("display_on", want.display_on, got.display_on);
          check_field("buzzer_active", want.buzzer_active, got.buzzer_active);
          check_field("save_strobe", want.save_strobe, got.save_strobe);
          check_field("setpoint_value", want.setpoint_value, got.setpoint_value);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_INITIAL_SETPOINT) setpoint_q = cfg_data[7:0];
        else blank_after = cfg_data;
      end
      if (s_tvalid && s_tready)
        predicted_results.push_back(step_controller(s_tdata[11:0]));
    end
    awaiting = predicted_results.size();
  end

endmodule

### tb/sv/tb_thermostat_alarm_controller_core.sv
`timescale 1ns / 100ps

module tb_thermostat_alarm_controller_core;
  import thac_pkg::*;

  localparam int RUN_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int unsigned fail_total;
  int unsigned awaiting;
  int unsigned cycle_count = 0;

  // Stimulus shaping
  logic        tx_gaps;
  logic        rx_gaps;
  logic        stall_req;
  logic [7:0]  temp_centre;

  thermostat_alarm_controller_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  thac_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_total),
    .awaiting   (awaiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random back-pressure bursts, one long hold on request
  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req     <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until taken; starts and ends at a falling edge
  task automatic offer_pass(input logic [7:0] temp, input logic k_set, input logic k_up,
                            input logic k_down, input logic tk);
    pass_in_t p;
    p.temperature = temp;
    p.key_set     = k_set;
    p.key_up      = k_up;
    p.key_down    = k_down;
    p.tick        = tk;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, p};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly temperatures around the set point, with some full-range and extreme values;
  // optionally hold the result side off while requests keep coming
  task automatic random_phase(input logic [7:0] sp, input logic [15:0] timeout,
                              input int count, input logic hold_rx);
    logic [7:0] temp;
    logic [7:0] jitter;
    int         pick;
    settle();
    write_reg(CFG_INITIAL_SETPOINT, {8'd0, sp});
    write_reg(CFG_IDLE_LIMIT, timeout);
    if (hold_rx) stall_req <= 1'b1;
    temp_centre = sp;
    for (int i = 0; i < count; i++) begin
      pick   = $urandom_range(0, 99);
      jitter = 8'($urandom_range(0, 12));
      if (pick < 60) temp = temp_centre + jitter - 8'd6;
      else if (pick < 90) temp = 8'($urandom_range(0, 255));
      else temp = pick[0] ? 8'd0 : 8'd255;
      offer_pass(temp, $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0,
                 $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_INITIAL_SETPOINT;
    cfg_data      = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    stall_req     = 1'b0;
    temp_centre   = INITIAL_SETPOINT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Timeout, pre-set, setting, save and the alarm path with a short timeout
    write_reg(CFG_INITIAL_SETPOINT, 16'd30);
    write_reg(CFG_IDLE_LIMIT, 16'd2);
    offer_pass(8'd0,   0, 0, 0, 0);
    offer_pass(8'd29,  0, 0, 0, 1);
    offer_pass(8'd30,  0, 0, 0, 1);  // blank on timeout
    offer_pass(8'd25,  0, 1, 0, 0);  // up stays latched in waiting
    offer_pass(8'd25,  1, 0, 0, 0);  // into pre-set, relit
    offer_pass(8'd25,  0, 0, 0, 1);
    offer_pass(8'd25,  0, 0, 0, 1);  // pre-set expires without restarting the timer
    offer_pass(8'd25,  1, 0, 0, 0);
    offer_pass(8'd25,  1, 0, 1, 0);  // into setting
    offer_pass(8'd25,  0, 0, 0, 0);  // latched up and down both apply
    offer_pass(8'd25,  0, 1, 1, 0);
    offer_pass(8'd25,  0, 1, 0, 1);
    offer_pass(8'd25,  1, 0, 0, 0);  // save
    offer_pass(8'd255, 1, 0, 0, 0);  // set pressed but over temperature wins
    offer_pass(8'd255, 0, 0, 0, 1);
    offer_pass(8'd255, 0, 0, 0, 0);
    offer_pass(8'd255, 1, 0, 0, 0);  // acknowledge
    offer_pass(8'd255, 0, 0, 0, 1);
    offer_pass(8'd0,   0, 0, 0, 0);  // cooled below the set point
    offer_pass(8'd200, 0, 0, 0, 0);
    offer_pass(8'd200, 0, 0, 0, 0);
    offer_pass(8'd200, 1, 0, 0, 0);
    offer_pass(8'd10,  1, 0, 0, 0);  // set beats the return to waiting

    // Set point wrap at zero and a zero timeout
    settle();
    write_reg(CFG_INITIAL_SETPOINT, 16'd0);
    write_reg(CFG_IDLE_LIMIT, 16'd0);
    offer_pass(8'd0, 1, 0, 0, 0);
    offer_pass(8'd0, 0, 0, 0, 0);
    offer_pass(8'd0, 1, 0, 0, 0);
    offer_pass(8'd0, 1, 0, 0, 0);
    offer_pass(8'd0, 0, 0, 1, 0);
    offer_pass(8'd0, 0, 1, 0, 0);
    offer_pass(8'd0, 0, 0, 1, 1);
    offer_pass(8'd0, 1, 0, 0, 0);

    // Random phases over several settings; the first holds the result side off for a while
    random_phase(8'd100, 16'd20, 85, 1'b1);
    rx_gaps = 1'b0;
    random_phase(8'd0, 16'd1, 85, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    random_phase(8'd255, 16'hFFFF, 85, 1'b0);
    tx_gaps = 1'b1;
    random_phase(8'd128, 16'd0, 85, 1'b0);
    random_phase(8'd200, 16'd5, 85, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_phase(8'd60, 16'd10000, 85, 1'b0);

    settle();
    if (fail_total == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
